/* src/tlca_pkg.sv */
// Shared types and codes for the tree ancestor and distance unit.
`timescale 1ns / 1ps

package tlca_pkg;

  // Command codes carried in the cmd field
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_BUILD = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // Register index on the configuration port
  localparam logic REG_NODE_COUNT = 1'b0;

  // Field widths fixed by the interface
  localparam int unsigned NODE_W = 10;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned DIST_W = 11;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_BRD,   // build: read entry of node i one level down
    ST_BE,    // build: first entry back, follow it
    ST_BW,    // build: second entry back, write new level
    ST_DRD,   // depth: read next level or write depth
    ST_DEV,   // depth: evaluate entry
    ST_QDA,   // query: depth of first node back
    ST_QDB,   // query: depth of second node back, order pair
    ST_QLRD,  // query: lift deeper node, read
    ST_QLEV,  // query: lift deeper node, evaluate
    ST_QX,    // query: check meeting point
    ST_QTRD,  // query: joint lift, read first node
    ST_QTA,   // query: first entry back, read second node
    ST_QTB,   // query: second entry back, evaluate
    ST_QFA,   // query: final parent of first node back
    ST_QFB,   // query: final parent of second node back
    ST_QOUT   // query: load result register
  } state_t;

endpackage

/* src/tree_lca_distance_unit.sv */
// Top level: binary-lifting ancestor table, depth store and query sequencer.
`timescale 1ns / 1ps

// Rooted tree (node 0 is the root) held in a jump table memory of NODES*LEVELS
// words and a depth memory of NODES words, both RAMs with a registered read.
// A load word writes the parent of a non-root node when both nodes lie below
// the node count. A build word fills the upper levels and then the depths; a
// query holds off the next word until its result is loaded, which waits while
// an earlier result is held on a stalled output. The build and the query share
// the single read port of the jump table.
// No word is taken while a build or a query runs; a finished result waits in
// its output register while the next word is accepted. The table is not
// cleared after reset: parents must be loaded and a build done before queries
// are valid.
module tree_lca_distance_unit
  import tlca_pkg::*;
#(
  parameter int unsigned NODES  = 1024,
  parameter int unsigned LEVELS = 10
) (
  input  logic              clk,
  input  logic              rst,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // item channel
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [1:0]        cmd,
  input  logic [NODE_W-1:0] node_a,
  input  logic [NODE_W-1:0] node_b,
  // result channel
  output logic              result_valid,
  input  logic              result_stall,
  output logic [DIST_W-1:0] distance,
  output logic [NODE_W-1:0] ancestor,
  output logic              bad_node
);

  localparam int unsigned NW  = $clog2(NODES);
  localparam int unsigned EW  = NW + 1;
  localparam int unsigned LW  = $clog2(LEVELS + 1);
  localparam int unsigned JD  = NODES * LEVELS;
  localparam int unsigned AW  = (JD > 2) ? $clog2(JD) : 1;
  localparam int unsigned DW  = LEVELS + 2;
  localparam int unsigned CW  = (NW + 1 > CNT_W) ? NW + 1 : CNT_W;

  // jump table address: level-major rows of NODES entries
  function automatic logic [AW-1:0] jaddr(input logic [NW-1:0] n, input logic [LW-1:0] l);
    return AW'(l) * AW'(NODES) + AW'(n);
  endfunction

  // configuration register
  logic [CNT_W-1:0] node_count;
  logic [CW-1:0]    cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= CNT_W'(1);
    end else if (psel && penable && pwrite && paddr[2] == REG_NODE_COUNT) begin
      node_count <= pwdata[CNT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NODE_COUNT) ? 32'(node_count) : 32'd0;
  assign cnt    = (CW'(node_count) < CW'(NODES)) ? CW'(node_count) : CW'(NODES);

  // memories
  logic [EW-1:0]     jt_mem [JD];
  logic [LEVELS-1:0] dm_mem [NODES];

  logic              jt_re, jt_we, dm_re, dm_we;
  logic [NW-1:0]     jt_rn;
  logic [LW-1:0]     jt_rl;
  logic [AW-1:0]     jt_wa;
  logic [EW-1:0]     jt_wd;
  logic [NW-1:0]     dm_ra, dm_wa;
  logic [LEVELS-1:0] dm_wd;
  logic [EW-1:0]     jt_rd;
  logic              jt_null;
  logic [LEVELS-1:0] dm_rd;

  always_ff @(posedge clk) begin
    if (jt_we) begin
      jt_mem[jt_wa] <= jt_wd;
    end
    if (jt_re) begin
      jt_rd   <= jt_mem[jaddr(jt_rn, jt_rl)];
      // the root never gets a parent at level zero
      jt_null <= (jt_rn == '0) && (jt_rl == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (dm_we) begin
      dm_mem[dm_wa] <= dm_wd;
    end
    if (dm_re) begin
      dm_rd <= dm_mem[dm_ra];
    end
  end

  logic          e_v;
  logic [NW-1:0] e_i;
  assign e_v = jt_rd[NW] && !jt_null;
  assign e_i = jt_rd[NW-1:0];

  // sequencer state
  state_t            st, st_next;
  logic [LW-1:0]     lvl, lvl_next;
  logic [NW-1:0]     idx, idx_next;
  logic [NW-1:0]     x, x_next, y, y_next;
  logic [LEVELS-1:0] d, d_next, diff, diff_next;
  logic [DW-1:0]     path_len, path_len_next;
  logic              ea_v, ea_v_next;
  logic [NW-1:0]     ea_i, ea_i_next;
  logic              bad, bad_next;
  logic              out_load;
  logic [LW-1:0]     lvl_m1;
  logic              accept;

  assign item_stall = (st != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign lvl_m1     = lvl - LW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    lvl      <= lvl_next;
    idx      <= idx_next;
    x        <= x_next;
    y        <= y_next;
    d        <= d_next;
    diff     <= diff_next;
    path_len <= path_len_next;
    ea_v     <= ea_v_next;
    ea_i     <= ea_i_next;
    bad      <= bad_next;
  end

  // next state, memory controls
  always_comb begin
    st_next       = st;
    lvl_next      = lvl;
    idx_next      = idx;
    x_next        = x;
    y_next        = y;
    d_next        = d;
    diff_next     = diff;
    path_len_next = path_len;
    ea_v_next     = ea_v;
    ea_i_next     = ea_i;
    bad_next      = bad;
    jt_re         = 1'b0;
    jt_rn         = x;
    jt_rl         = lvl_m1;
    jt_we         = 1'b0;
    jt_wa         = jaddr(idx, lvl);
    jt_wd         = '0;
    dm_re         = 1'b0;
    dm_ra         = x;
    dm_we         = 1'b0;
    dm_wa         = idx;
    dm_wd         = d;
    out_load      = 1'b0;

    case (st)
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_LOAD: begin
              jt_wa = jaddr(NW'(node_a), '0);
              jt_wd = {1'b1, NW'(node_b)};
              jt_we = (node_a != '0) && (CW'(node_a) < cnt) && (CW'(node_b) < cnt);
            end
            CMD_BUILD: begin
              idx_next = '0;
              if (LEVELS > 1) begin
                lvl_next = LW'(1);
                st_next  = ST_BRD;
              end else begin
                x_next   = '0;
                d_next   = '0;
                lvl_next = LW'(LEVELS);
                st_next  = ST_DRD;
              end
            end
            CMD_QUERY: begin
              path_len_next = '0;
              if ((CW'(node_a) >= cnt) || (CW'(node_b) >= cnt)) begin
                bad_next = 1'b1;
                st_next  = ST_QOUT;
              end else begin
                bad_next = 1'b0;
                x_next   = NW'(node_a);
                y_next   = NW'(node_b);
                dm_ra    = NW'(node_a);
                dm_re    = 1'b1;
                st_next  = ST_QDA;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // build upper levels: entry(i,l) = entry(entry(i,l-1), l-1)
      ST_BRD: begin
        jt_rn   = idx;
        jt_re   = 1'b1;
        st_next = ST_BE;
      end
      ST_BE, ST_BW: begin
        if (st == ST_BE && e_v) begin
          jt_rn   = e_i;
          jt_re   = 1'b1;
          st_next = ST_BW;
        end else begin
          jt_we = 1'b1;
          jt_wd = (st == ST_BW && e_v) ? jt_rd : '0;
          if (idx == NW'(NODES - 1)) begin
            idx_next = '0;
            if (lvl == LW'(LEVELS - 1)) begin
              x_next   = '0;
              d_next   = '0;
              lvl_next = LW'(LEVELS);
              st_next  = ST_DRD;
            end else begin
              lvl_next = lvl + LW'(1);
              st_next  = ST_BRD;
            end
          end else begin
            idx_next = idx + NW'(1);
            st_next  = ST_BRD;
          end
        end
      end

      // depth of node i by lifting to the top
      ST_DRD: begin
        if (lvl == '0) begin
          dm_we = 1'b1;
          if (idx == NW'(NODES - 1)) begin
            st_next = ST_IDLE;
          end else begin
            idx_next = idx + NW'(1);
            x_next   = idx + NW'(1);
            d_next   = '0;
            lvl_next = LW'(LEVELS);
          end
        end else begin
          jt_re    = 1'b1;
          lvl_next = lvl_m1;
          st_next  = ST_DEV;
        end
      end
      ST_DEV: begin
        if (e_v) begin
          x_next = e_i;
          d_next = d + (LEVELS'(1) << lvl);
        end
        st_next = ST_DRD;
      end

      // query: fetch depths and order the pair
      ST_QDA: begin
        d_next  = dm_rd;
        dm_ra   = y;
        dm_re   = 1'b1;
        st_next = ST_QDB;
      end
      ST_QDB: begin
        if (d < dm_rd) begin
          x_next    = y;
          y_next    = x;
          diff_next = dm_rd - d;
        end else begin
          diff_next = d - dm_rd;
        end
        lvl_next = LW'(LEVELS);
        st_next  = ST_QLRD;
      end

      // lift deeper node by the depth difference
      ST_QLRD: begin
        if (lvl == '0) begin
          st_next = ST_QX;
        end else begin
          lvl_next = lvl_m1;
          if (diff[lvl_m1]) begin
            jt_re   = 1'b1;
            st_next = ST_QLEV;
          end
        end
      end
      ST_QLEV: begin
        if (e_v) begin
          x_next        = e_i;
          path_len_next = path_len + (DW'(1) << lvl);
        end
        st_next = ST_QLRD;
      end
      ST_QX: begin
        lvl_next = LW'(LEVELS);
        st_next  = (x == y) ? ST_QOUT : ST_QTRD;
      end

      // lift both while their ancestors differ
      ST_QTRD: begin
        jt_re = 1'b1;
        if (lvl == '0) begin
          jt_rl   = '0;
          st_next = ST_QFA;
        end else begin
          lvl_next = lvl_m1;
          st_next  = ST_QTA;
        end
      end
      ST_QTA: begin
        ea_v_next = e_v;
        ea_i_next = e_i;
        jt_rn     = y;
        jt_rl     = lvl;
        jt_re     = 1'b1;
        st_next   = ST_QTB;
      end
      ST_QTB: begin
        if (ea_v && e_v && ea_i != e_i) begin
          x_next        = ea_i;
          y_next        = e_i;
          path_len_next = path_len + (DW'(2) << lvl);
        end
        st_next = ST_QTRD;
      end

      // final step to the common parent
      ST_QFA: begin
        ea_v_next = e_v;
        ea_i_next = e_i;
        jt_rn     = y;
        jt_rl     = '0;
        jt_re     = 1'b1;
        st_next   = ST_QFB;
      end
      ST_QFB: begin
        if (!ea_v || !e_v || ea_i != e_i) begin
          bad_next = 1'b1;
        end else begin
          x_next        = ea_i;
          path_len_next = path_len + DW'(2);
        end
        st_next = ST_QOUT;
      end

      ST_QOUT: begin
        if (!(result_valid && result_stall)) begin
          out_load = 1'b1;
          st_next  = ST_IDLE;
        end
      end

      default: begin
        st_next = ST_IDLE;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      bad_node <= bad;
      if (bad) begin
        distance <= '0;
        ancestor <= '0;
      end else begin
        distance <= (32'(path_len) > 32'(DIST_MAX)) ? DIST_MAX : DIST_W'(path_len);
        ancestor <= NODE_W'(x);
      end
    end
  end

endmodule

/* src/tlca_checker.sv */
// Port-level checks for the tree ancestor and distance unit, with bind.
`timescale 1ns / 1ps

module tlca_checker
  import tlca_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              pready,
  input logic              item_valid,
  input logic              item_stall,
  input logic [1:0]        cmd,
  input logic              result_valid,
  input logic              result_stall,
  input logic [DIST_W-1:0] distance,
  input logic [NODE_W-1:0] ancestor,
  input logic              bad_node
);

  // a held result word keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(distance)
      && $stable(ancestor) && $stable(bad_node))
    else $error("stalled result word changed");

  // a flagged answer carries no distance and no ancestor
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && bad_node |-> distance == '0 && ancestor == '0)
    else $error("bad result word not zeroed");

  // loads and builds never produce a result word
  a_no_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && cmd != CMD_QUERY && !result_valid |=> !result_valid)
    else $error("result word from a non-query");

  // a build keeps the item side busy afterwards
  a_build_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && cmd == CMD_BUILD |=> item_stall)
    else $error("item taken right after build");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind tree_lca_distance_unit tlca_checker u_tlca_checker (
  .clk          (clk),
  .rst          (rst),
  .pready       (pready),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .cmd          (cmd),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .distance     (distance),
  .ancestor     (ancestor),
  .bad_node     (bad_node)
);
